@@ rtl/tunnel_peer_table_macros.svh @@
// Assertion helpers for the RTL back end.
`ifndef TUNNEL_PEER_TABLE_MACROS_SVH
`define TUNNEL_PEER_TABLE_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define TPT_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("tpt check failed");
// Check that a condition implies a consequence in the next cycle.
`define TPT_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("tpt check failed");
`endif

@@ rtl/tpt_pkg.sv @@
package tpt_pkg;
   localparam int PEER_SLOTS = 16;
   localparam int SLOT_W = $clog2(PEER_SLOTS);
   localparam logic [31:0] EXPIRY_SECONDS = 32'd30;
   localparam logic [1:0] MAX_BUBBLES = 2'd3;
   localparam logic [31:0] BUBBLE_GAP = 32'd2;
   localparam logic [15:0] SERVER_PORT = 16'd3544;
   localparam int QDEPTH = 2;

   localparam logic [1:0] CSR_PREFIX = 2'd0;
   localparam logic [1:0] CSR_QUALIFIED = 2'd1;
   localparam logic [1:0] CSR_CONE = 2'd2;

   typedef enum logic [2:0] {
      ACT_DROP = 3'd0, ACT_ERROR = 3'd1, ACT_FORWARD = 3'd2, ACT_HELD = 3'd3,
      ACT_BUB_SRV = 3'd4, ACT_BUB_DIR = 3'd5, ACT_SEND_HELD = 3'd6, ACT_DELIVER = 3'd7
   } action_type;

   // request after front-end classification
   typedef struct packed {
      logic        inbound;
      logic        early;       // answer known without table lookup
      action_type  early_act;
      logic        may_alloc;   // outbound: allowed to create an entry
      logic        bubble;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] now;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic        valid;
      action_type  act;
      logic [31:0] ip;
      logic [15:0] port;
      logic        last;
   } rsp_type;
endpackage

@@ rtl/tunnel_peer_table.sv @@
// A request rejected up front is queued, taken by the back end in idle and answered in emit;
// a table request is taken in idle, then passes the slot scan and decide before emit.
// The back end takes a new request only after it has emitted every result of the last one.
// The receiver cannot stall results.
// A two-entry request queue lets start be taken while the back end scans.
// Reset (synchronous, active high) clears all slots and loads register defaults.
module tunnel_peer_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_peer_addr_hi,
   input  logic [63:0] req_peer_addr_lo,
   input  logic [31:0] req_now_sec,
   input  logic        req_header_ok,
   input  logic        req_other_end_teredo,
   input  logic        req_client_global,
   input  logic        req_source_matches,
   input  logic        req_is_bubble,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_target_ip,
   output logic [15:0] rsp_target_port,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tpt_pkg::*;

   logic [31:0] prefix_ff;
   logic        qual_ff, cone_ff;
   job_type     job;
   logic        job_valid, job_pop;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '1;
         qual_ff <= 1'b0;
         cone_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PREFIX:    prefix_ff <= csr_wdata;
            CSR_QUALIFIED: qual_ff <= csr_wdata[0];
            CSR_CONE:      cone_ff <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   // classify and queue each request
   tpt_front u_front (
      .clock, .reset,
      .req_start(start), .req_busy(busy),
      .req_func, .req_peer_addr_hi, .req_peer_addr_lo, .req_now_sec,
      .req_header_ok, .req_other_end_teredo, .req_client_global,
      .req_source_matches, .req_is_bubble,
      .own_prefix(prefix_ff), .qualified(qual_ff),
      .job, .job_valid, .job_pop
   );

   // scan the table, update the entry, emit results
   tpt_back u_back (
      .clock, .reset, .job, .job_valid, .job_pop,
      .own_cone(cone_ff),
      .rsp_strobe, .rsp_action, .rsp_target_ip, .rsp_target_port, .rsp_last
   );
endmodule

@@ rtl/tpt_front.sv @@
module tpt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   output logic                  req_busy,
   input  logic                  req_func,
   input  logic [63:0]           req_peer_addr_hi,
   input  logic [63:0]           req_peer_addr_lo,
   input  logic [31:0]           req_now_sec,
   input  logic                  req_header_ok,
   input  logic                  req_other_end_teredo,
   input  logic                  req_client_global,
   input  logic                  req_source_matches,
   input  logic                  req_is_bubble,
   input  logic [31:0]           own_prefix,
   input  logic                  qualified,
   output tpt_pkg::job_type      job,
   output logic                  job_valid,
   input  logic                  job_pop
);
   import tpt_pkg::*;

   job_type   q_ff [QDEPTH];
   logic [$clog2(QDEPTH+1)-1:0] cnt_ff, cnt_in;
   logic      wp_ff, rp_ff;
   job_type   cls;
   logic      push, pref_ok;

   assign req_busy  = (cnt_ff == QDEPTH[$clog2(QDEPTH+1)-1:0]);
   assign push      = req_start && !req_busy;
   assign pref_ok   = (req_peer_addr_hi[63:32] == own_prefix);

   // classify the request
   always_comb begin
      cls = '0;
      cls.inbound = req_func;
      cls.hi = req_peer_addr_hi;
      cls.lo = req_peer_addr_lo;
      cls.now = req_now_sec;
      cls.bubble = req_is_bubble;
      cls.early_act = ACT_DROP;
      if (!req_func) begin
         cls.may_alloc = pref_ok && req_client_global;
         if (!qualified) begin
            cls.early = 1'b1;
            cls.early_act = ACT_ERROR;
         end else if (!req_header_ok || (!pref_ok && !req_other_end_teredo)) begin
            cls.early = 1'b1;
         end
      end else if (!qualified || !req_header_ok || !pref_ok || !req_source_matches) begin
         cls.early = 1'b1;
      end
   end

   assign job       = q_ff[rp_ff];
   assign job_valid = (cnt_ff != '0);
   assign cnt_in    = cnt_ff + {{($bits(cnt_ff)-1){1'b0}}, push}
                      - {{($bits(cnt_ff)-1){1'b0}}, job_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (job_pop) rp_ff <= ~rp_ff;
      end
      if (push) q_ff[wp_ff] <= cls;
   end
endmodule

@@ rtl/tpt_back.sv @@
module tpt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tpt_pkg::job_type      job,
   input  logic                  job_valid,
   output logic                  job_pop,
   input  logic                  own_cone,
   output logic                  rsp_strobe,
   output logic [2:0]            rsp_action,
   output logic [31:0]           rsp_target_ip,
   output logic [15:0]           rsp_target_port,
   output logic                  rsp_last
);
   import tpt_pkg::*;
`include "tunnel_peer_table_macros.svh"

   logic [PEER_SLOTS-1:0] valid_ff;
   logic [63:0] kh_m [PEER_SLOTS];
   logic [63:0] kl_m [PEER_SLOTS];
   logic [31:0] ip_m [PEER_SLOTS];
   logic [15:0] pt_m [PEER_SLOTS];
   logic [4:0]  fl_m [PEER_SLOTS];
   logic [31:0] rx_m [PEER_SLOTS];
   logic [31:0] tx_m [PEER_SLOTS];

   state_type   st_ff, st_in;
   job_type     j_ff;
   logic [SLOT_W:0] idx_ff;
   logic [SLOT_W-1:0] sidx;
   logic        hit_ff, exp_ff, free_ff;
   logic [SLOT_W-1:0] hit_s_ff, exp_s_ff, free_s_ff;
   logic        s_valid, s_exp, s_match;
   logic [31:0] s_t;
   rsp_type     r_ff [3];
   logic [1:0]  rn_ff, ri_ff;
   rsp_type     r_in [3];
   logic [1:0]  rn_in;
   logic        wr_en;
   logic [SLOT_W-1:0] wr_s;
   logic [63:0] w_kh, w_kl;
   logic [31:0] w_ip, w_rx, w_tx;
   logic [15:0] w_pt;
   logic [4:0]  w_fl;
   logic        scan_done;

   assign sidx     = idx_ff[SLOT_W-1:0];
   assign s_valid  = valid_ff[sidx];
   assign s_t      = fl_m[sidx][1] ? rx_m[sidx] : tx_m[sidx];
   assign s_exp    = (j_ff.now - s_t) > EXPIRY_SECONDS;
   assign s_match  = (kh_m[sidx] == j_ff.hi) && (kl_m[sidx] == j_ff.lo);
   assign scan_done = (idx_ff == PEER_SLOTS[SLOT_W:0]);
   assign job_pop  = (st_ff == ST_IDLE) && job_valid;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:   if (job_valid) st_in = job.early ? ST_EMIT : ST_SCAN;
         ST_SCAN:   if (scan_done) st_in = ST_DECIDE;
         ST_DECIDE: st_in = ST_EMIT;
         ST_EMIT:   if (ri_ff == rn_ff) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   // decide: results and write-back for the matched or new entry
   always_comb begin
      logic [SLOT_W-1:0] s;
      logic [4:0]  f;
      logic [31:0] ip, tx;
      logic [15:0] pt;
      logic [1:0]  bub;
      logic        ok;
      s = hit_s_ff; f = fl_m[s]; ip = ip_m[s]; pt = pt_m[s]; tx = tx_m[s];
      bub = '0; ok = 1'b1;
      rn_in = 2'd0;
      for (int k = 0; k < 3; k++) r_in[k] = '0;
      wr_en = 1'b0; wr_s = s;
      w_kh = kh_m[s]; w_kl = kl_m[s]; w_ip = ip; w_pt = pt; w_fl = f;
      w_rx = rx_m[s]; w_tx = tx;
      if (j_ff.inbound) begin
         if (hit_ff) begin
            wr_en = 1'b1;
            w_fl = f | 5'b00011;
            w_rx = j_ff.now;
            if (f[4]) begin
               w_fl[4] = 1'b0;
               r_in[rn_in] = '{1'b1, ACT_SEND_HELD, ip, pt, 1'b0};
               rn_in = rn_in + 2'd1;
            end
            if (!j_ff.bubble) begin
               r_in[rn_in] = '{1'b1, ACT_DELIVER, 32'd0, 16'd0, 1'b0};
               rn_in = rn_in + 2'd1;
            end
         end
      end else if (hit_ff && f[0]) begin
         wr_en = 1'b1;
         w_tx = j_ff.now;
         r_in[0] = '{1'b1, ACT_FORWARD, ip, pt, 1'b0};
         rn_in = 2'd1;
      end else if (j_ff.may_alloc) begin
         if (!hit_ff) begin
            if (exp_ff) s = exp_s_ff;
            else if (free_ff) s = free_s_ff;
            else ok = 1'b0;
            wr_s = s;
            w_kh = j_ff.hi; w_kl = j_ff.lo;
            ip = ~j_ff.lo[31:0]; pt = ~j_ff.lo[47:32];
            f = '0; tx = j_ff.now;
            w_ip = ip; w_pt = pt; w_rx = j_ff.now;
         end
         if (!ok) begin
            r_in[0] = '{1'b1, ACT_ERROR, 32'd0, 16'd0, 1'b0};
            rn_in = 2'd1;
         end else begin
            wr_en = 1'b1;
            if (j_ff.lo[63]) begin
               f[0] = 1'b1;
               r_in[0] = '{1'b1, ACT_FORWARD, ip, pt, 1'b0};
               rn_in = 2'd1;
            end else begin
               r_in[0] = '{1'b1, f[4] ? ACT_DROP : ACT_HELD, 32'd0, 16'd0, 1'b0};
               rn_in = 2'd1;
               f[4] = 1'b1;
               bub = f[3:2];
               if (bub < MAX_BUBBLES && (bub == 2'd0 || (j_ff.now - tx) >= BUBBLE_GAP)) begin
                  f[3:2] = bub + 2'd1;
                  tx = j_ff.now;
                  if (!own_cone) begin
                     r_in[rn_in] = '{1'b1, ACT_BUB_SRV, j_ff.hi[31:0], SERVER_PORT, 1'b0};
                     rn_in = rn_in + 2'd1;
                  end
                  r_in[rn_in] = '{1'b1, ACT_BUB_DIR, ip, pt, 1'b0};
                  rn_in = rn_in + 2'd1;
               end
            end
            w_fl = f; w_tx = tx;
         end
      end
      if (rn_in == 2'd0) begin
         r_in[0] = '{1'b1, ACT_DROP, 32'd0, 16'd0, 1'b0};
         rn_in = 2'd1;
      end
      r_in[rn_in - 2'd1].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         valid_ff <= '0;
         rn_ff <= '0;
         ri_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_IDLE && job_valid) begin
            ri_ff <= '0;
            if (job.early) begin
               rn_ff <= 2'd1;
               r_ff[0] <= '{1'b1, job.early_act, 32'd0, 16'd0, 1'b1};
            end
         end else if (st_ff == ST_DECIDE) begin
            rn_ff <= rn_in;
            ri_ff <= '0;
            if (wr_en) valid_ff[wr_s] <= 1'b1;
         end else if (st_ff == ST_EMIT) begin
            ri_ff <= ri_ff + 2'd1;
         end
      end
      if (st_ff == ST_IDLE && job_valid) begin
         j_ff <= job;
         idx_ff <= '0;
         hit_ff <= 1'b0; exp_ff <= 1'b0; free_ff <= 1'b0;
      end
      // scan one slot a cycle: first live match, first expired, first free
      if (st_ff == ST_SCAN && !scan_done) begin
         idx_ff <= idx_ff + 1'b1;
         if (s_valid && s_match && !s_exp && !hit_ff) begin
            hit_ff <= 1'b1; hit_s_ff <= sidx;
         end
         if (s_valid && s_exp && !exp_ff) begin
            exp_ff <= 1'b1; exp_s_ff <= sidx;
         end
         if (!s_valid && !free_ff) begin
            free_ff <= 1'b1; free_s_ff <= sidx;
         end
      end
      if (st_ff == ST_DECIDE) begin
         for (int k = 0; k < 3; k++) r_ff[k] <= r_in[k];
         if (wr_en) begin
            kh_m[wr_s] <= w_kh; kl_m[wr_s] <= w_kl;
            ip_m[wr_s] <= w_ip; pt_m[wr_s] <= w_pt;
            fl_m[wr_s] <= w_fl; rx_m[wr_s] <= w_rx; tx_m[wr_s] <= w_tx;
         end
      end
   end

   assign rsp_strobe      = (st_ff == ST_EMIT) && (ri_ff != rn_ff);
   assign rsp_action      = r_ff[ri_ff].act;
   assign rsp_target_ip   = r_ff[ri_ff].ip;
   assign rsp_target_port = r_ff[ri_ff].port;
   assign rsp_last        = r_ff[ri_ff].last;

   `TPT_ASSERT_IMP(a_pop_idle, clock, reset, job_pop, st_ff == ST_IDLE)
   `TPT_ASSERT_NEXT(a_last_ends, clock, reset, rsp_strobe && rsp_last, !rsp_strobe)
   `TPT_ASSERT_IMP(a_emit_count, clock, reset, st_ff == ST_EMIT, ri_ff <= rn_ff)
endmodule
